// ===== sv/fern_pkg.sv =====
// ----------------------------------------------------------------------------
// fern_pkg: shared types, constants and tables for the fern point generator
// Fixed-point formats, affine map coefficients, map colors, register indexes
// and the microcode program of the step sequencer.
// ----------------------------------------------------------------------------
package fern_pkg;

    // Number formats
    localparam int FRAC_BITS = 16;
    localparam int RAND_BITS = 16;
    localparam int PT_W      = 32;
    localparam int COEF_W    = FRAC_BITS + 2;
    localparam int PROD_W    = FRAC_BITS + 33;
    localparam int ACC_W     = PROD_W + 3;
    localparam int RND_W     = ACC_W - FRAC_BITS;
    localparam int PIX_W     = 12;
    localparam int SIZE_W    = 13;
    localparam int DIFF_W    = PT_W + 1;
    localparam int DVS_W     = PT_W;
    localparam int DVD_W     = PT_W + PIX_W;
    localparam int CNT_W     = $clog2(DVD_W + 1);
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int RGB_W     = 24;

    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(1 << PIX_W);
    localparam logic [PIX_W-1:0]  PIX_MAX  = {PIX_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_X_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_X_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_Y_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_Y_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

    // Register reset values
    localparam logic signed [PT_W-1:0] RST_VIEW_X_MIN = -32'sd196608;
    localparam logic signed [PT_W-1:0] RST_VIEW_X_MAX = 32'sd196608;
    localparam logic signed [PT_W-1:0] RST_VIEW_Y_MIN = 32'sd0;
    localparam logic signed [PT_W-1:0] RST_VIEW_Y_MAX = 32'sd720896;
    localparam logic [SIZE_W-1:0]      RST_IMAGE_W    = 13'd1024;
    localparam logic [SIZE_W-1:0]      RST_IMAGE_H    = 13'd768;

    // Map codes
    localparam logic [1:0] MAP_STEM  = 2'd0;
    localparam logic [1:0] MAP_MAIN  = 2'd1;
    localparam logic [1:0] MAP_LEFT  = 2'd2;
    localparam logic [1:0] MAP_RIGHT = 2'd3;

    // Coefficient terms: output coordinate, input coordinate
    localparam logic [1:0] TERM_XX = 2'd0;
    localparam logic [1:0] TERM_XY = 2'd1;
    localparam logic [1:0] TERM_YX = 2'd2;
    localparam logic [1:0] TERM_YY = 2'd3;

    // Coefficient in thousandths, rounded to FRAC_BITS
    function automatic longint fx(input longint milli);
        return (milli * (longint'(1) <<< FRAC_BITS) + 500) / 1000;
    endfunction

    // Probability in percent, rounded to RAND_BITS
    function automatic longint thr(input longint pct);
        return (pct * (longint'(1) <<< RAND_BITS) + 50) / 100;
    endfunction

    localparam logic [RAND_BITS-1:0] THR_STEM = RAND_BITS'(thr(1));
    localparam logic [RAND_BITS-1:0] THR_MAIN = RAND_BITS'(thr(86));
    localparam logic [RAND_BITS-1:0] THR_LEFT = RAND_BITS'(thr(93));

    // Pick the affine map from a uniform random value
    function automatic logic [1:0] map_pick(input logic [RAND_BITS-1:0] r);
        if (r < THR_STEM) begin
            return MAP_STEM;
        end else if (r < THR_MAIN) begin
            return MAP_MAIN;
        end else if (r < THR_LEFT) begin
            return MAP_LEFT;
        end
        return MAP_RIGHT;
    endfunction

    // Linear coefficient of one term of one map
    function automatic logic signed [COEF_W-1:0] coef(input logic [1:0] m,
                                                      input logic [1:0] t);
        longint c;
        c = 0;
        case ({m, t})
            {MAP_STEM,  TERM_YY}: c = fx(160);
            {MAP_MAIN,  TERM_XX}: c = fx(850);
            {MAP_MAIN,  TERM_XY}: c = fx(40);
            {MAP_MAIN,  TERM_YX}: c = -fx(40);
            {MAP_MAIN,  TERM_YY}: c = fx(850);
            {MAP_LEFT,  TERM_XX}: c = fx(200);
            {MAP_LEFT,  TERM_XY}: c = -fx(260);
            {MAP_LEFT,  TERM_YX}: c = fx(230);
            {MAP_LEFT,  TERM_YY}: c = fx(220);
            {MAP_RIGHT, TERM_XX}: c = -fx(150);
            {MAP_RIGHT, TERM_XY}: c = fx(280);
            {MAP_RIGHT, TERM_YX}: c = fx(260);
            {MAP_RIGHT, TERM_YY}: c = fx(240);
            default:              c = 0;
        endcase
        return COEF_W'(c);
    endfunction

    // Constant term of the y map, at product scale
    function automatic logic signed [ACC_W-1:0] offset(input logic [1:0] m);
        longint o;
        o = 0;
        case (m)
            MAP_MAIN:  o = fx(1600) <<< FRAC_BITS;
            MAP_LEFT:  o = fx(1600) <<< FRAC_BITS;
            MAP_RIGHT: o = fx(440) <<< FRAC_BITS;
            default:   o = 0;
        endcase
        return ACC_W'(o);
    endfunction

    function automatic logic [RGB_W-1:0] map_color(input logic [1:0] m);
        case (m)
            MAP_STEM:  return 24'h8B4513;
            MAP_MAIN:  return 24'h228B22;
            MAP_LEFT:  return 24'hFFD700;
            default:   return 24'hFF4500;
        endcase
    endfunction

    // Control word fields
    typedef enum logic [2:0] {
        MUL_NONE, MUL_CXX, MUL_CXY, MUL_CYX, MUL_CYY, MUL_PX, MUL_PY
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_CLR, ACC_ADD, ACC_OFS_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        PT_HOLD, PT_SAVE_X, PT_COMMIT
    } pt_op_t;

    typedef enum logic [1:0] {
        DIV_HOLD, DIV_START_X, DIV_START_Y, DIV_STEP
    } div_op_t;

    typedef enum logic {
        RES_HOLD, RES_X
    } res_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT, JMP_DIV, JMP_OUT
    } jmp_t;

    typedef struct packed {
        mul_op_t mul_op;
        acc_op_t acc_op;
        pt_op_t  pt_op;
        div_op_t div_op;
        res_op_t res_op;
        jmp_t    jmp;
    } ctrl_t;

    localparam ctrl_t CTRL_IDLE = '{MUL_NONE, ACC_HOLD, PT_HOLD, DIV_HOLD, RES_HOLD, JMP_NEXT};

    // Microcode program, one control word per step
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t cw;
        cw = CTRL_IDLE;
        case (step)
            4'd0: begin
                cw.mul_op = MUL_CXX;
                cw.acc_op = ACC_CLR;
            end
            4'd1: begin
                cw.mul_op = MUL_CXY;
                cw.acc_op = ACC_ADD;
            end
            4'd2: begin
                cw.mul_op = MUL_CYX;
                cw.acc_op = ACC_ADD;
            end
            4'd3: begin
                cw.mul_op = MUL_CYY;
                cw.acc_op = ACC_OFS_ADD;
                cw.pt_op  = PT_SAVE_X;
            end
            4'd4: begin
                cw.acc_op = ACC_ADD;
            end
            4'd5: begin
                cw.pt_op = PT_COMMIT;
            end
            4'd6: begin
                cw.mul_op = MUL_PX;
            end
            4'd7: begin
                cw.mul_op = MUL_PY;
                cw.div_op = DIV_START_X;
            end
            4'd8: begin
                cw.div_op = DIV_STEP;
                cw.jmp    = JMP_DIV;
            end
            4'd9: begin
                cw.res_op = RES_X;
                cw.div_op = DIV_START_Y;
            end
            4'd10: begin
                cw.div_op = DIV_STEP;
                cw.jmp    = JMP_DIV;
            end
            default: begin
                cw.jmp = JMP_OUT;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== sv/fern_ifs_point_generator.sv =====
// ----------------------------------------------------------------------------
// fern_ifs_point_generator: chaos-game step of the Barnsley fern
// Picks an affine map from a random value, updates the stored point and
// maps it onto the pixel grid of the view window, run by a microcode sequencer.
// ----------------------------------------------------------------------------
// An accepted item runs the map steps, two bit-serial divisions by one shared
//   restoring divider and the result steps before it reaches m_valid.
// One item is in work at a time: s_ready stays low until its result is loaded.
// The next item is taken while a result waits in the output register.
// Reset (aresetn low, synchronous): point to origin, view registers to their
//   defaults, sequencer idle, output register empty.
module fern_ifs_point_generator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [fern_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fern_pkg::PT_W-1:0]          cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [fern_pkg::RAND_BITS-1:0]     s_rand_value,
    input  logic                               s_restart,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [fern_pkg::PIX_W-1:0]         m_pixel_x,
    output logic [fern_pkg::PIX_W-1:0]         m_pixel_y,
    output logic                               m_in_bounds,
    output logic [1:0]                         m_map_index,
    output logic [fern_pkg::RGB_W-1:0]         m_color_rgb
);

    localparam int PT_W   = fern_pkg::PT_W;
    localparam int ACC_W  = fern_pkg::ACC_W;
    localparam int PROD_W = fern_pkg::PROD_W;
    localparam int RND_W  = fern_pkg::RND_W;
    localparam int DIFF_W = fern_pkg::DIFF_W;
    localparam int DVD_W  = fern_pkg::DVD_W;
    localparam int DVS_W  = fern_pkg::DVS_W;
    localparam int CNT_W  = fern_pkg::CNT_W;
    localparam int PIX_W  = fern_pkg::PIX_W;
    localparam int SIZE_W = fern_pkg::SIZE_W;
    localparam int STEP_W = fern_pkg::STEP_W;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (fern_pkg::FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] PT_MAX   = RND_W'(32'sh7FFFFFFF);
    localparam logic signed [RND_W-1:0] PT_MIN   = RND_W'(32'sh80000000);

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             inb;
    } pix_res_t;

    // Registers
    logic signed [PT_W-1:0]   view_x_min_reg, view_x_max_reg, view_y_min_reg, view_y_max_reg;
    logic [SIZE_W-1:0]        image_w_reg, image_h_reg;
    logic                     busy_reg, busy_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [1:0]               map_reg;
    logic signed [PT_W-1:0]   point_x_reg, point_x_next;
    logic signed [PT_W-1:0]   point_y_reg, point_y_next;
    logic signed [PT_W-1:0]   nx_reg, nx_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [DVD_W-1:0]         q_reg, q_next;
    logic [DVS_W-1:0]         rem_reg, rem_next;
    logic [DVS_W-1:0]         dvs_reg, dvs_next;
    logic                     div_neg_reg, div_neg_next;
    logic [CNT_W-1:0]         div_cnt_reg, div_cnt_next;
    pix_res_t                 res_x_reg, res_x_next;
    logic                     m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]         pix_x_reg, pix_y_reg;
    logic                     inb_reg;
    logic [1:0]               map_out_reg;
    logic [fern_pkg::RGB_W-1:0] color_reg;

    // Combinational signals
    fern_pkg::ctrl_t          cw;
    logic                     in_acc;
    logic                     out_free;
    logic                     out_load;
    logic [SIZE_W-1:0]        size_w, size_h;
    logic signed [DIFF_W-1:0] diff_x, diff_y, den_x, den_y;
    logic                     ok_x, ok_y;
    logic signed [DIFF_W-1:0] mul_a;
    logic signed [PT_W-1:0]   mul_b;
    logic signed [DIFF_W+PT_W-1:0] mul_full;
    logic signed [ACC_W-1:0]  rnd_add;
    logic signed [RND_W-1:0]  rnd_shr;
    logic signed [PT_W-1:0]   rnd_pt;
    logic signed [PROD_W-1:0] prod_abs;
    logic signed [DIFF_W-1:0] den_sel, den_abs;
    logic [DVS_W:0]           div_shift;
    logic [DVS_W+1:0]         div_trial;
    pix_res_t                 res_now_x, res_now_y;

    // Turn a quotient magnitude and sign into a saturated pixel and bounds flag
    function automatic pix_res_t pix_eval(input logic [DVD_W-1:0] q,
                                          input logic neg,
                                          input logic ok,
                                          input logic [SIZE_W-1:0] size);
        pix_res_t r;
        logic     neg_nz;
        neg_nz = neg && (q != '0);
        if (!ok || neg_nz) begin
            r.pix = '0;
        end else if (q > DVD_W'(fern_pkg::PIX_MAX)) begin
            r.pix = {PIX_W{1'b1}};
        end else begin
            r.pix = q[PIX_W-1:0];
        end
        r.inb = ok && !neg_nz && (q < DVD_W'(size));
        return r;
    endfunction

    assign in_acc   = s_valid && s_ready;
    assign s_ready  = !busy_reg;
    assign cw       = busy_reg ? fern_pkg::ucode(step_reg) : fern_pkg::CTRL_IDLE;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = busy_reg && (cw.jmp == fern_pkg::JMP_OUT) && out_free;

    // Clamp image size and form the window differences
    assign size_w = (image_w_reg > fern_pkg::SIZE_MAX) ? fern_pkg::SIZE_MAX : image_w_reg;
    assign size_h = (image_h_reg > fern_pkg::SIZE_MAX) ? fern_pkg::SIZE_MAX : image_h_reg;
    assign diff_x = DIFF_W'(point_x_reg) - DIFF_W'(view_x_min_reg);
    assign diff_y = DIFF_W'(view_y_max_reg) - DIFF_W'(point_y_reg);
    assign den_x  = DIFF_W'(view_x_max_reg) - DIFF_W'(view_x_min_reg);
    assign den_y  = DIFF_W'(view_y_max_reg) - DIFF_W'(view_y_min_reg);
    assign ok_x   = (den_x != '0);
    assign ok_y   = (den_y != '0);

    // Select multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cw.mul_op)
            fern_pkg::MUL_CXX: begin
                mul_a = DIFF_W'(fern_pkg::coef(map_reg, fern_pkg::TERM_XX));
                mul_b = point_x_reg;
            end
            fern_pkg::MUL_CXY: begin
                mul_a = DIFF_W'(fern_pkg::coef(map_reg, fern_pkg::TERM_XY));
                mul_b = point_y_reg;
            end
            fern_pkg::MUL_CYX: begin
                mul_a = DIFF_W'(fern_pkg::coef(map_reg, fern_pkg::TERM_YX));
                mul_b = point_x_reg;
            end
            fern_pkg::MUL_CYY: begin
                mul_a = DIFF_W'(fern_pkg::coef(map_reg, fern_pkg::TERM_YY));
                mul_b = point_y_reg;
            end
            fern_pkg::MUL_PX: begin
                mul_a = diff_x;
                mul_b = $signed({{(PT_W-SIZE_W){1'b0}}, size_w});
            end
            fern_pkg::MUL_PY: begin
                mul_a = diff_y;
                mul_b = $signed({{(PT_W-SIZE_W){1'b0}}, size_h});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Round half up to the point format and saturate
    assign rnd_add = acc_reg + ACC_HALF;
    assign rnd_shr = $signed(rnd_add[ACC_W-1:fern_pkg::FRAC_BITS]);
    assign rnd_pt  = (rnd_shr > PT_MAX) ? PT_MAX[PT_W-1:0] :
                     (rnd_shr < PT_MIN) ? PT_MIN[PT_W-1:0] : rnd_shr[PT_W-1:0];

    // Divider operands and one restoring step
    assign prod_abs  = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign den_sel   = (cw.div_op == fern_pkg::DIV_START_Y) ? den_y : den_x;
    assign den_abs   = den_sel[DIFF_W-1] ? -den_sel : den_sel;
    assign div_shift = {rem_reg, q_reg[DVD_W-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, dvs_reg};

    assign res_now_x = pix_eval(q_reg, div_neg_reg, ok_x, size_w);
    assign res_now_y = pix_eval(q_reg, div_neg_reg, ok_y, size_h);

    // Sequencer: next step
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg) begin
            if (in_acc) begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end else begin
            case (cw.jmp)
                fern_pkg::JMP_NEXT: begin
                    step_next = step_reg + STEP_W'(1);
                end
                fern_pkg::JMP_DIV: begin
                    if (div_cnt_reg == CNT_W'(1)) begin
                        step_next = step_reg + STEP_W'(1);
                    end
                end
                fern_pkg::JMP_OUT: begin
                    if (out_free) begin
                        busy_next = 1'b0;
                        step_next = '0;
                    end
                end
                default: begin
                    step_next = step_reg;
                end
            endcase
        end
    end

    // Datapath: multiplier, accumulator and point registers
    always_comb begin
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        nx_next      = nx_reg;
        point_x_next = point_x_reg;
        point_y_next = point_y_reg;

        if (cw.mul_op != fern_pkg::MUL_NONE) begin
            prod_next = mul_full[PROD_W-1:0];
        end

        case (cw.acc_op)
            fern_pkg::ACC_CLR:     acc_next = '0;
            fern_pkg::ACC_ADD:     acc_next = acc_reg + ACC_W'(prod_reg);
            fern_pkg::ACC_OFS_ADD: acc_next = fern_pkg::offset(map_reg) + ACC_W'(prod_reg);
            default:               acc_next = acc_reg;
        endcase

        case (cw.pt_op)
            fern_pkg::PT_SAVE_X: begin
                nx_next = rnd_pt;
            end
            fern_pkg::PT_COMMIT: begin
                point_x_next = nx_reg;
                point_y_next = rnd_pt;
            end
            default: begin
                nx_next = nx_reg;
            end
        endcase

        // Clear the point on a restart item
        if (in_acc && s_restart) begin
            point_x_next = '0;
            point_y_next = '0;
        end
    end

    // Divider: load magnitudes, then shift one quotient bit per cycle
    always_comb begin
        q_next       = q_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        div_neg_next = div_neg_reg;
        div_cnt_next = div_cnt_reg;
        case (cw.div_op)
            fern_pkg::DIV_START_X, fern_pkg::DIV_START_Y: begin
                q_next       = prod_abs[DVD_W-1:0];
                rem_next     = '0;
                dvs_next     = den_abs[DVS_W-1:0];
                div_neg_next = prod_reg[PROD_W-1] ^ den_sel[DIFF_W-1];
                div_cnt_next = CNT_W'(DVD_W);
            end
            fern_pkg::DIV_STEP: begin
                if (!div_trial[DVS_W+1]) begin
                    rem_next = div_trial[DVS_W-1:0];
                end else begin
                    rem_next = div_shift[DVS_W-1:0];
                end
                q_next       = {q_reg[DVD_W-2:0], !div_trial[DVS_W+1]};
                div_cnt_next = div_cnt_reg - CNT_W'(1);
            end
            default: begin
                q_next = q_reg;
            end
        endcase
    end

    // Results: hold the x pixel, release the output item
    always_comb begin
        res_x_next   = res_x_reg;
        m_valid_next = m_valid_reg;
        if (cw.res_op == fern_pkg::RES_X) begin
            res_x_next = res_now_x;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            step_reg       <= '0;
            m_valid_reg    <= 1'b0;
            div_cnt_reg    <= '0;
            point_x_reg    <= '0;
            point_y_reg    <= '0;
            view_x_min_reg <= fern_pkg::RST_VIEW_X_MIN;
            view_x_max_reg <= fern_pkg::RST_VIEW_X_MAX;
            view_y_min_reg <= fern_pkg::RST_VIEW_Y_MIN;
            view_y_max_reg <= fern_pkg::RST_VIEW_Y_MAX;
            image_w_reg    <= fern_pkg::RST_IMAGE_W;
            image_h_reg    <= fern_pkg::RST_IMAGE_H;
        end else begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            div_cnt_reg <= div_cnt_next;
            point_x_reg <= point_x_next;
            point_y_reg <= point_y_next;
            if (cfg_we) begin
                case (cfg_index)
                    fern_pkg::REG_VIEW_X_MIN:   view_x_min_reg <= cfg_wdata;
                    fern_pkg::REG_VIEW_X_MAX:   view_x_max_reg <= cfg_wdata;
                    fern_pkg::REG_VIEW_Y_MIN:   view_y_min_reg <= cfg_wdata;
                    fern_pkg::REG_VIEW_Y_MAX:   view_y_max_reg <= cfg_wdata;
                    fern_pkg::REG_IMAGE_WIDTH:  image_w_reg    <= cfg_wdata[SIZE_W-1:0];
                    fern_pkg::REG_IMAGE_HEIGHT: image_h_reg    <= cfg_wdata[SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        nx_reg      <= nx_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        div_neg_reg <= div_neg_next;
        res_x_reg   <= res_x_next;
        if (in_acc) begin
            map_reg <= fern_pkg::map_pick(s_rand_value);
        end
        if (out_load) begin
            pix_x_reg   <= res_x_reg.pix;
            pix_y_reg   <= res_now_y.pix;
            inb_reg     <= res_x_reg.inb && res_now_y.inb;
            map_out_reg <= map_reg;
            color_reg   <= fern_pkg::map_color(map_reg);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_x   = pix_x_reg;
    assign m_pixel_y   = pix_y_reg;
    assign m_in_bounds = inb_reg;
    assign m_map_index = map_out_reg;
    assign m_color_rgb = color_reg;

    // Assertions
    a_accept_at_step0: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (busy_reg && step_reg == '0))
        else $error("accepted item did not start the program at step zero");

    a_div_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_cnt_reg != '0) |-> busy_reg)
        else $error("divider running while sequencer idle");

    a_result_from_program: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(busy_reg) && !busy_reg)
        else $error("result released outside the final program step");

endmodule
